// ===== src/lfws_pkg.sv =====
package lfws_pkg;

    localparam int RING_DEPTH = 10;
    localparam int USER_COUNT = 128;
    localparam int TIME_BITS  = 48;

    localparam int USER_BITS  = 7;
    localparam int EVT_TIME_BITS = 48;
    localparam int SCORE_BITS = 16;
    localparam int WIN_BITS   = 32;
    localparam int THR_BITS   = 4;
    localparam int PEN_BITS   = 8;
    localparam int CNT_BITS   = 4;

    localparam int SLOT_BITS  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_BITS  = $clog2(RING_DEPTH + 1);
    localparam int UA_BITS    = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;
    localparam int TIME_DEPTH = USER_COUNT * RING_DEPTH;
    localparam int TA_BITS    = (TIME_DEPTH > 1) ? $clog2(TIME_DEPTH) : 1;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FAIL_PEN   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESTR_PEN  = 2'd3;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET    = 32'd30000;
    localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 4'd3;
    localparam logic [PEN_BITS-1:0] FAIL_PEN_RESET  = 8'd5;
    localparam logic [PEN_BITS-1:0] RESTR_PEN_RESET = 8'd10;

    localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

    typedef struct packed {
        logic [SLOT_BITS-1:0]  head;
        logic [FILL_BITS-1:0]  fill;
        logic [SCORE_BITS-1:0] score;
    } t_ustate;

    localparam int USTATE_BITS = $bits(t_ustate);

    typedef struct packed {
        logic clear;
        logic en;
    } t_age_ctl;

    // Fold head + offset back into the ring; the sum is below twice the depth.
    function automatic logic [SLOT_BITS-1:0] wrap_slot(input logic [SLOT_BITS:0] sum);
        logic [SLOT_BITS:0] depth_ext;
        depth_ext = (SLOT_BITS + 1)'(RING_DEPTH);
        if (sum >= depth_ext) begin
            wrap_slot = SLOT_BITS'(sum - depth_ext);
        end else begin
            wrap_slot = SLOT_BITS'(sum);
        end
    endfunction

    function automatic logic [SCORE_BITS-1:0] sat_add(
        input logic [SCORE_BITS-1:0] score,
        input logic [PEN_BITS-1:0]   pen
    );
        logic [SCORE_BITS:0] sum;
        sum = {1'b0, score} + (SCORE_BITS + 1)'(pen);
        sat_add = sum[SCORE_BITS] ? SCORE_MAX : sum[SCORE_BITS-1:0];
    endfunction

endpackage

// ===== src/lfws_evt_if.sv =====
interface lfws_evt_if;
    logic                                 valid;
    logic                                 ready;
    logic [lfws_pkg::USER_BITS-1:0]       user_id;
    logic                                 is_failed_login;
    logic                                 is_restricted;
    logic [lfws_pkg::EVT_TIME_BITS-1:0]   event_time;

    modport source(output valid, user_id, is_failed_login, is_restricted, event_time,
                   input ready);
    modport sink(input valid, user_id, is_failed_login, is_restricted, event_time,
                 output ready);
endinterface

// ===== src/lfws_res_if.sv =====
interface lfws_res_if;
    logic                              valid;
    logic                              ready;
    logic [lfws_pkg::USER_BITS-1:0]    user_echo;
    logic [lfws_pkg::SCORE_BITS-1:0]   user_score;
    logic [lfws_pkg::CNT_BITS-1:0]     recent_fails;
    logic                              fail_alert;

    modport source(output valid, user_echo, user_score, recent_fails, fail_alert,
                   input ready);
    modport sink(input valid, user_echo, user_score, recent_fails, fail_alert,
                 output ready);
endinterface

// ===== src/lfws_ram.sv =====
module lfws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/lfws_age_unit.sv =====
module lfws_age_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lfws_pkg::t_age_ctl                  i_ctl,
    input  logic [lfws_pkg::TIME_BITS-1:0]      i_now,
    input  logic [lfws_pkg::TIME_BITS-1:0]      i_then,
    input  logic [lfws_pkg::WIN_BITS-1:0]       i_window,
    output logic [lfws_pkg::FILL_BITS-1:0]      o_count
);
    localparam int CMP_BITS = (lfws_pkg::TIME_BITS > lfws_pkg::WIN_BITS) ?
                              lfws_pkg::TIME_BITS : lfws_pkg::WIN_BITS;

    logic [lfws_pkg::TIME_BITS:0]   w_diff;
    logic                           w_recent;
    logic [lfws_pkg::FILL_BITS-1:0] r_count;
    logic [lfws_pkg::FILL_BITS-1:0] n_count;

    // A borrow means the stored time is later than now: that entry counts.
    assign w_diff   = {1'b0, i_now} - {1'b0, i_then};
    assign w_recent = w_diff[lfws_pkg::TIME_BITS] ||
                      (CMP_BITS'(w_diff[lfws_pkg::TIME_BITS-1:0]) <= CMP_BITS'(i_window));

    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.en && w_recent) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
endmodule

// ===== src/login_failure_window_scorer_core.sv =====
// Flow: an accepted event is registered in IDLE, its per-user state is read in LOAD, a
// failed login then walks its ring in SCAN (fill = ring entries after push, 1..10), and
// FIN writes the result once the output register is free, waiting while it is held. A new
// event is taken only in IDLE, after the last one has left FIN; the ring walk reads one
// stored timestamp per cycle through the single time-memory read port and one shared age comparator.
// Reset (synchronous, active low) clears scores and ring counts and loads register defaults.
module login_failure_window_scorer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lfws_evt_if.sink                             i_evt,
    lfws_res_if.source                           o_res,
    input  logic                                 i_cfg_we,
    input  logic [lfws_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [lfws_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state, n_state;

    logic [lfws_pkg::WIN_BITS-1:0] r_win;
    logic [lfws_pkg::THR_BITS-1:0] r_thr;
    logic [lfws_pkg::PEN_BITS-1:0] r_fpen;
    logic [lfws_pkg::PEN_BITS-1:0] r_rpen;

    logic [lfws_pkg::USER_BITS-1:0]  r_user, n_user;
    logic                            r_failed, n_failed;
    logic                            r_restr, n_restr;
    logic                            r_user_ok, n_user_ok;
    logic [lfws_pkg::TIME_BITS-1:0]  r_now, n_now;
    logic [lfws_pkg::SLOT_BITS-1:0]  r_head, n_head;
    logic [lfws_pkg::FILL_BITS-1:0]  r_fill, n_fill;
    logic [lfws_pkg::SCORE_BITS-1:0] r_score, n_score;
    logic [lfws_pkg::FILL_BITS-1:0]  r_idx, n_idx;
    logic                            r_pend, n_pend;

    logic                            r_uvld [lfws_pkg::USER_COUNT];

    logic                             r_out_vld, n_out_vld;
    logic [lfws_pkg::USER_BITS-1:0]   r_out_user, n_out_user;
    logic [lfws_pkg::SCORE_BITS-1:0]  r_out_score, n_out_score;
    logic [lfws_pkg::CNT_BITS-1:0]    r_out_cnt, n_out_cnt;
    logic                             r_out_alert, n_out_alert;

    logic                             w_accept;
    logic                             w_out_free;
    logic                             w_fin_go;

    logic [lfws_pkg::USTATE_BITS-1:0] w_us_rdata;
    lfws_pkg::t_ustate                w_us_rd;
    lfws_pkg::t_ustate                w_us_cur;
    lfws_pkg::t_ustate                w_us_wr;
    logic [lfws_pkg::UA_BITS-1:0]     w_us_raddr;
    logic [lfws_pkg::UA_BITS-1:0]     w_user_addr;

    logic [lfws_pkg::TA_BITS-1:0]     w_base;
    logic                             w_t_we;
    logic [lfws_pkg::TA_BITS-1:0]     w_t_waddr;
    logic [lfws_pkg::TA_BITS-1:0]     w_t_raddr;
    logic [lfws_pkg::TIME_BITS-1:0]   w_t_rdata;

    logic [lfws_pkg::SLOT_BITS-1:0]   w_ld_head;
    logic [lfws_pkg::FILL_BITS-1:0]   w_ld_fill;
    logic [lfws_pkg::SLOT_BITS-1:0]   w_push_slot;
    logic [lfws_pkg::SLOT_BITS-1:0]   w_scan_slot;

    lfws_pkg::t_age_ctl               w_age_ctl;
    logic [lfws_pkg::FILL_BITS-1:0]   w_count;

    logic                             w_alert;
    logic [lfws_pkg::SCORE_BITS-1:0]  w_score1;
    logic [lfws_pkg::SCORE_BITS-1:0]  w_score2;

    assign w_accept   = i_evt.valid && i_evt.ready;
    assign w_out_free = !r_out_vld || o_res.ready;
    assign w_fin_go   = (r_state == S_FIN) && w_out_free;

    assign i_evt.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_vld;
    assign o_res.user_echo   = r_out_user;
    assign o_res.user_score  = r_out_score;
    assign o_res.recent_fails = r_out_cnt;
    assign o_res.fail_alert  = r_out_alert;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= lfws_pkg::WINDOW_RESET;
            r_thr  <= lfws_pkg::THRESHOLD_RESET;
            r_fpen <= lfws_pkg::FAIL_PEN_RESET;
            r_rpen <= lfws_pkg::RESTR_PEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lfws_pkg::CFG_WINDOW:    r_win  <= i_cfg_data[lfws_pkg::WIN_BITS-1:0];
                lfws_pkg::CFG_THRESHOLD: r_thr  <= i_cfg_data[lfws_pkg::THR_BITS-1:0];
                lfws_pkg::CFG_FAIL_PEN:  r_fpen <= i_cfg_data[lfws_pkg::PEN_BITS-1:0];
                lfws_pkg::CFG_RESTR_PEN: r_rpen <= i_cfg_data[lfws_pkg::PEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Per-user head, fill and score
    assign w_user_addr = lfws_pkg::UA_BITS'(r_user);
    assign w_us_raddr  = lfws_pkg::UA_BITS'(i_evt.user_id);
    assign w_us_rd     = lfws_pkg::t_ustate'(w_us_rdata);
    assign w_us_cur    = r_uvld[w_user_addr] ? w_us_rd : '0;
    assign w_us_wr     = '{head: r_head, fill: r_fill, score: w_score2};

    lfws_ram #(
        .WIDTH(lfws_pkg::USTATE_BITS),
        .DEPTH(lfws_pkg::USER_COUNT)
    ) u_ustate_ram (
        .i_clk  (i_clk),
        .i_we   (w_fin_go && r_user_ok),
        .i_waddr(w_user_addr),
        .i_wdata(w_us_wr),
        .i_raddr(w_us_raddr),
        .o_rdata(w_us_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int u = 0; u < lfws_pkg::USER_COUNT; u++) begin
                r_uvld[u] <= 1'b0;
            end
        end else if (w_fin_go && r_user_ok) begin
            r_uvld[w_user_addr] <= 1'b1;
        end
    end

    // Failure timestamp ring storage
    assign w_base = lfws_pkg::TA_BITS'(r_user) * lfws_pkg::TA_BITS'(lfws_pkg::RING_DEPTH);

    always_comb begin
        w_ld_head = w_us_cur.head;
        w_ld_fill = w_us_cur.fill;
        if (w_us_cur.fill == lfws_pkg::FILL_BITS'(lfws_pkg::RING_DEPTH)) begin
            // drop the oldest entry
            w_ld_head = lfws_pkg::wrap_slot({1'b0, w_us_cur.head} + 1'b1);
            w_ld_fill = w_us_cur.fill - 1'b1;
        end
    end

    assign w_push_slot = lfws_pkg::wrap_slot((lfws_pkg::SLOT_BITS + 1)'(w_ld_head) +
                                             (lfws_pkg::SLOT_BITS + 1)'(w_ld_fill));
    assign w_scan_slot = lfws_pkg::wrap_slot((lfws_pkg::SLOT_BITS + 1)'(r_head) +
                                             (lfws_pkg::SLOT_BITS + 1)'(r_idx));

    assign w_t_we    = (r_state == S_LOAD) && r_user_ok && r_failed;
    assign w_t_waddr = w_base + lfws_pkg::TA_BITS'(w_push_slot);
    assign w_t_raddr = w_base + lfws_pkg::TA_BITS'(w_scan_slot);

    lfws_ram #(
        .WIDTH(lfws_pkg::TIME_BITS),
        .DEPTH(lfws_pkg::TIME_DEPTH)
    ) u_time_ram (
        .i_clk  (i_clk),
        .i_we   (w_t_we),
        .i_waddr(w_t_waddr),
        .i_wdata(r_now),
        .i_raddr(w_t_raddr),
        .o_rdata(w_t_rdata)
    );

    assign w_age_ctl.clear = (r_state == S_LOAD);
    assign w_age_ctl.en    = (r_state == S_SCAN) && r_pend;

    lfws_age_unit u_age (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_age_ctl),
        .i_now   (r_now),
        .i_then  (w_t_rdata),
        .i_window(r_win),
        .o_count (w_count)
    );

    // Score update
    assign w_alert  = r_user_ok && r_failed && (32'(w_count) >= 32'(r_thr));
    assign w_score1 = w_alert ? lfws_pkg::sat_add(r_score, r_fpen) : r_score;
    assign w_score2 = r_restr ? lfws_pkg::sat_add(w_score1, r_rpen) : w_score1;

    always_comb begin
        n_state     = r_state;
        n_user      = r_user;
        n_failed    = r_failed;
        n_restr     = r_restr;
        n_user_ok   = r_user_ok;
        n_now       = r_now;
        n_head      = r_head;
        n_fill      = r_fill;
        n_score     = r_score;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_out_vld   = r_out_vld && !o_res.ready;
        n_out_user  = r_out_user;
        n_out_score = r_out_score;
        n_out_cnt   = r_out_cnt;
        n_out_alert = r_out_alert;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_user    = i_evt.user_id;
                    n_failed  = i_evt.is_failed_login;
                    n_restr   = i_evt.is_restricted;
                    n_now     = lfws_pkg::TIME_BITS'(i_evt.event_time);
                    n_user_ok = (32'(i_evt.user_id) < 32'(lfws_pkg::USER_COUNT));
                    n_state   = S_LOAD;
                end
            end
            S_LOAD: begin
                n_score = w_us_cur.score;
                n_head  = w_us_cur.head;
                n_fill  = w_us_cur.fill;
                n_idx   = '0;
                n_pend  = 1'b0;
                if (r_user_ok && r_failed) begin
                    n_head  = w_ld_head;
                    n_fill  = w_ld_fill + 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                // issue one ring read per cycle; each compare happens in the cycle after its read
                if (r_idx != r_fill) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_user  = r_user;
                    n_out_score = r_user_ok ? w_score2 : '0;
                    n_out_cnt   = (r_user_ok && r_failed) ?
                                  lfws_pkg::CNT_BITS'(w_count) : '0;
                    n_out_alert = w_alert;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_user      <= n_user;
        r_failed    <= n_failed;
        r_restr     <= n_restr;
        r_user_ok   <= n_user_ok;
        r_now       <= n_now;
        r_head      <= n_head;
        r_fill      <= n_fill;
        r_score     <= n_score;
        r_out_user  <= n_out_user;
        r_out_score <= n_out_score;
        r_out_cnt   <= n_out_cnt;
        r_out_alert <= n_out_alert;
    end

    a_alert_meets_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.fail_alert) |-> (32'(o_res.recent_fails) >= 32'(r_thr)))
        else $error("fail alert raised below threshold");

    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_idx <= r_fill) && (w_count <= r_idx) &&
                                 (32'(r_fill) <= 32'(lfws_pkg::RING_DEPTH))))
        else $error("ring walk out of bounds");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOAD))
        else $error("accepted event not loaded");

    a_no_fail_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_go && !r_failed) |=> ((o_res.recent_fails == '0) && !o_res.fail_alert))
        else $error("count reported for an event without failure");
endmodule

// ===== bench/tb_login_failure_window_scorer_core.sv =====
module tb_login_failure_window_scorer_core;
    import lfws_pkg::*;

    typedef struct {
        logic [USER_BITS-1:0]     user;
        logic                     failed;
        logic                     restricted;
        logic [EVT_TIME_BITS-1:0] stamp;
        bit                       drain;
    } log_evt_t;

    typedef struct {
        logic [USER_BITS-1:0]  user_echo;
        logic [SCORE_BITS-1:0] user_score;
        logic [CNT_BITS-1:0]   recent_fails;
        logic                  fail_alert;
    } score_rec_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    lfws_evt_if evt_bus();
    lfws_res_if res_bus();

    login_failure_window_scorer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt_bus),
        .o_res      (res_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mirror of the block: per-user failure rings, ring pointers and scores.
    bit [EVT_TIME_BITS-1:0] fail_ring [USER_COUNT][RING_DEPTH];
    int unsigned            ring_oldest [USER_COUNT];
    int unsigned            ring_count [USER_COUNT];
    bit [SCORE_BITS-1:0]    score_mirror [USER_COUNT];

    bit [WIN_BITS-1:0] window_m    = WINDOW_RESET;
    bit [THR_BITS-1:0] threshold_m = THRESHOLD_RESET;
    bit [PEN_BITS-1:0] fail_pen_m  = FAIL_PEN_RESET;
    bit [PEN_BITS-1:0] restr_pen_m = RESTR_PEN_RESET;

    log_evt_t   pending_events[$];
    score_rec_t expected_scores[$];
    log_evt_t   in_flight;

    int events_taken   = 0;
    int scores_seen    = 0;
    int mismatch_count = 0;
    int saturated_seen = 0;
    int alerts_seen    = 0;
    int settings_used  = 1;
    int gap_max        = 0;
    int stall_max      = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    bit [EVT_TIME_BITS-1:0] base_tick = '0;

    function automatic bit [SCORE_BITS-1:0] capped_add(bit [SCORE_BITS-1:0] acc,
                                                       bit [PEN_BITS-1:0] pen);
        bit [SCORE_BITS:0] sum;
        sum = {1'b0, acc} + {{(SCORE_BITS + 1 - PEN_BITS){1'b0}}, pen};
        return sum[SCORE_BITS] ? {SCORE_BITS{1'b1}} : sum[SCORE_BITS-1:0];
    endfunction

    function automatic score_rec_t score_event(log_evt_t e);
        score_rec_t             r;
        int unsigned            u;
        int unsigned            oldest;
        int unsigned            held;
        int unsigned            hits;
        bit [EVT_TIME_BITS-1:0] then_t;
        bit [SCORE_BITS-1:0]    sc;
        bit                     alert;
        u = e.user;
        hits = 0;
        alert = 1'b0;
        sc = '0;
        if (u < USER_COUNT) begin
            sc = score_mirror[u];
            if (e.failed) begin
                oldest = ring_oldest[u];
                held = ring_count[u];
                // drop the oldest entry when the ring is full
                if (held == RING_DEPTH) begin
                    oldest = (oldest + 1) % RING_DEPTH;
                    held--;
                end
                fail_ring[u][(oldest + held) % RING_DEPTH] = e.stamp;
                held++;
                ring_oldest[u] = oldest;
                ring_count[u] = held;
                for (int i = 0; i < held; i++) begin
                    then_t = fail_ring[u][(oldest + i) % RING_DEPTH];
                    // a stored time later than now has negative age and counts
                    if (e.stamp < then_t ||
                        (e.stamp - then_t) <= {{(EVT_TIME_BITS - WIN_BITS){1'b0}}, window_m})
                        hits++;
                end
                if (hits >= threshold_m) begin
                    alert = 1'b1;
                    sc = capped_add(sc, fail_pen_m);
                end
            end
            if (e.restricted)
                sc = capped_add(sc, restr_pen_m);
            score_mirror[u] = sc;
        end
        r.user_echo = e.user;
        r.user_score = sc;
        r.recent_fails = CNT_BITS'(hits);
        r.fail_alert = alert;
        return r;
    endfunction

    // Event driver
    always @(posedge i_clk) begin
        bit       nxt_valid;
        bit       xfer;
        log_evt_t nxt;
        if (!i_rst_n) begin
            evt_bus.valid <= 1'b0;
            gap_left = 0;
        end else begin
            nxt_valid = evt_bus.valid;
            xfer = evt_bus.valid && evt_bus.ready;
            if (xfer) begin
                expected_scores.push_back(score_event(in_flight));
                events_taken <= events_taken + 1;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_events.size() > 0) begin
                    // hold a draining event until every score is back
                    if (!pending_events[0].drain ||
                        (!xfer && events_taken == scores_seen)) begin
                        nxt = pending_events.pop_front();
                        in_flight = nxt;
                        evt_bus.user_id <= nxt.user;
                        evt_bus.is_failed_login <= nxt.failed;
                        evt_bus.is_restricted <= nxt.restricted;
                        evt_bus.event_time <= nxt.stamp;
                        nxt_valid = 1'b1;
                        gap_left = $urandom_range(0, gap_max);
                    end
                end
            end
            evt_bus.valid <= nxt_valid;
        end
    end

    // Score monitor
    always @(posedge i_clk) begin
        score_rec_t want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_scores.size() == 0) begin
                    $error("score for user %0d arrived with none outstanding",
                           res_bus.user_echo);
                    mismatch_count++;
                end else begin
                    want = expected_scores.pop_front();
                    if (res_bus.user_echo !== want.user_echo) begin
                        $error("user_echo mismatch: expected %0d, got %0d",
                               want.user_echo, res_bus.user_echo);
                        mismatch_count++;
                    end
                    if (res_bus.user_score !== want.user_score) begin
                        $error("user_score mismatch: expected %0d, got %0d",
                               want.user_score, res_bus.user_score);
                        mismatch_count++;
                    end
                    if (res_bus.recent_fails !== want.recent_fails) begin
                        $error("recent_fails mismatch: expected %0d, got %0d",
                               want.recent_fails, res_bus.recent_fails);
                        mismatch_count++;
                    end
                    if (res_bus.fail_alert !== want.fail_alert) begin
                        $error("fail_alert mismatch: expected %0d, got %0d",
                               want.fail_alert, res_bus.fail_alert);
                        mismatch_count++;
                    end
                    if (want.user_score == SCORE_MAX)
                        saturated_seen++;
                    if (want.fail_alert)
                        alerts_seen++;
                end
                scores_seen <= scores_seen + 1;
                stall_left = $urandom_range(0, stall_max);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            res_bus.ready <= (stall_left == 0);
        end
    end

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WINDOW:    window_m = data[WIN_BITS-1:0];
            CFG_THRESHOLD: threshold_m = data[THR_BITS-1:0];
            CFG_FAIL_PEN:  fail_pen_m = data[PEN_BITS-1:0];
            CFG_RESTR_PEN: restr_pen_m = data[PEN_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(bit [31:0] win, bit [31:0] thr, bit [31:0] fpen,
                                 bit [31:0] rpen);
        cfg_write(CFG_WINDOW, win);
        cfg_write(CFG_THRESHOLD, thr);
        cfg_write(CFG_FAIL_PEN, fpen);
        cfg_write(CFG_RESTR_PEN, rpen);
        settings_used++;
    endtask

    // Settle on a falling edge so queue and pacing updates never race the driver.
    task automatic start_phase(int gaps, int stalls);
        @(negedge i_clk);
        gap_max = gaps;
        stall_max = stalls;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (!(pending_events.size() == 0 && !evt_bus.valid &&
                 events_taken == scores_seen));
    endtask

    task automatic add_event(int user, bit failed, bit restricted,
                             bit [EVT_TIME_BITS-1:0] stamp);
        log_evt_t e;
        e.user = USER_BITS'(user);
        e.failed = failed;
        e.restricted = restricted;
        e.stamp = stamp;
        e.drain = 1'b0;
        pending_events.push_back(e);
    endtask

    // Mostly per-user bursts on a rising clock, with backward steps, jumps and noise.
    task automatic queue_random(int count, int span, int fail_pct, int restr_pct, int step);
        log_evt_t e;
        int       pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 7) == 0)
                e.user = USER_BITS'($urandom_range(0, USER_COUNT - 1));
            else
                e.user = USER_BITS'($urandom_range(0, span - 1));
            e.failed = ($urandom_range(0, 99) < fail_pct);
            e.restricted = ($urandom_range(0, 99) < restr_pct);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                base_tick += EVT_TIME_BITS'($urandom_range(0, step));
                e.stamp = base_tick;
            end else if (pick < 80) begin
                e.stamp = base_tick - EVT_TIME_BITS'($urandom_range(0, step));
            end else if (pick < 84) begin
                base_tick += EVT_TIME_BITS'({$urandom, $urandom});
                e.stamp = base_tick;
            end else if (pick < 90) begin
                e.stamp = EVT_TIME_BITS'({$urandom, $urandom});
            end else begin
                e.stamp = base_tick;
            end
            e.drain = (n == count / 2) || ($urandom_range(0, 199) == 0);
            pending_events.push_back(e);
        end
    endtask

    initial begin
        bit [31:0] win;
        evt_bus.valid = 1'b0;
        evt_bus.user_id = '0;
        evt_bus.is_failed_login = 1'b0;
        evt_bus.is_restricted = 1'b0;
        evt_bus.event_time = '0;
        res_bus.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed events on the reset settings.
        start_phase(3, 3);
        add_event(0, 1, 0, 48'd0);
        add_event(0, 1, 0, 48'd10000);
        add_event(0, 1, 0, 48'd20000);
        add_event(0, 1, 1, 48'd50000);         // entry from 20000 aged exactly one window
        add_event(0, 0, 0, 48'd60000);
        add_event(127, 0, 1, 48'hFFFF_FFFF_FFFF);
        add_event(127, 1, 0, 48'hFFFF_FFFF_FFFF);
        add_event(127, 1, 0, 48'hFFFF_FFFF_FFFF);
        add_event(127, 1, 0, 48'd0);           // clock stepped backwards
        add_event(42, 1, 1, 48'hAAAA_AAAA_AAAA);
        add_event(85, 1, 0, 48'h5555_5555_5555);
        for (int k = 0; k < 12; k++)           // overrun the ring
            add_event(21, 1, 0, 48'd1000 + 48'(100 * k));
        wait_idle();

        // Zero window, zero threshold, zero penalties.
        load_settings(32'd0, 32'd0, 32'd0, 32'd0);
        start_phase(0, 0);
        add_event(9, 1, 0, 48'd500);
        add_event(9, 1, 1, 48'd500);
        add_event(9, 1, 0, 48'd501);
        add_event(9, 0, 1, 48'd502);
        queue_random(120, 8, 60, 30, 2);
        wait_idle();

        // Widest window, full-ring threshold, largest penalties: drive scores to the cap.
        load_settings(32'hFFFF_FFFF, 32'd10, 32'd255, 32'd255);
        start_phase(17, 0);
        queue_random(500, 2, 50, 95, 1000);
        wait_idle();

        // Threshold beyond the ring depth is never reached.
        load_settings(32'd50, 32'd15, 32'd1, 32'd7);
        start_phase(0, 17);
        queue_random(150, 16, 70, 20, 40);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            win = $urandom_range(20, 200000);
            load_settings(win, $urandom_range(0, 10), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            start_phase((p % 2) ? 17 : $urandom_range(0, 6), (p > 2) ? 17 : 0);
            queue_random(210, 32, 65, 25, win / 3 + 1);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (expected_scores.size() != 0) begin
            $error("%0d scores never arrived", expected_scores.size());
            mismatch_count++;
        end
        $display("Checked %0d scores from %0d events over %0d register settings",
                 scores_seen, events_taken, settings_used);
        $display("Failure alerts: %0d, scores pinned at the cap: %0d",
                 alerts_seen, saturated_seen);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
